FILE: rtl/core/base64_stream_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_SAME(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!(r)) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NEXT(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!(r)) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/core/b64d_pkg.sv
// Shared constants, command type and count helper for the base64 decoder.
`default_nettype none
package b64d_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int OUT_COUNT_W = 24;
	localparam int CNT_EXT_W   = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;
	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One command: up to three bytes for the back end to emit.
	typedef struct packed {
		logic [7:0]             b0;
		logic [7:0]             b1;
		logic [7:0]             b2;
		logic [1:0]             nbytes;
		logic                   eos;
		logic [OUT_COUNT_W-1:0] count;
	} cmd_t;

	// Clamp the internal byte total to the width of the reported count.
	function automatic logic [OUT_COUNT_W-1:0] count_to_out(input logic [COUNT_WIDTH-1:0] c);
		logic [CNT_EXT_W-1:0] ext;
		ext = CNT_EXT_W'(c);
		if (ext > CNT_EXT_W'(OUT_COUNT_MAX)) begin
			return OUT_COUNT_MAX;
		end
		return ext[OUT_COUNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/b64d_front.sv
// Front end: classify characters, track group phase and byte total, issue commands.
`default_nettype none
module b64d_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic [7:0]     code_char,
	input  wire logic           q_full,
	output logic                q_wr,
	output b64d_pkg::cmd_t      q_cmd
);

	localparam int SUM_W = b64d_pkg::COUNT_WIDTH + 1;
	localparam logic [1:0] PH_ONE   = 2'd1;
	localparam logic [1:0] PH_TWO   = 2'd2;
	localparam logic [1:0] PH_THREE = 2'd3;
	localparam logic [1:0] NB_NONE  = 2'd0;
	localparam logic [1:0] NB_ONE   = 2'd1;
	localparam logic [1:0] NB_TWO   = 2'd2;
	localparam logic [1:0] NB_THREE = 2'd3;

	// bit 6 set means the byte lies outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] s;
		if (c inside {[8'h41:8'h5A]}) begin
			s = {1'b0, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			s = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin
			s = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			s = {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			s = {1'b0, 6'd63};
		end else begin
			s = 7'h40;
		end
		return s;
	endfunction

	function automatic logic [b64d_pkg::COUNT_WIDTH-1:0] sat_add(
		input logic [b64d_pkg::COUNT_WIDTH-1:0] t,
		input logic [1:0] n
	);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, t} + SUM_W'(n);
		if (sum[SUM_W-1]) begin
			return '1;
		end
		return sum[SUM_W-2:0];
	endfunction

	logic [1:0]                        ph_q, ph_d;
	logic [17:0]                       pend_q, pend_d;
	logic [b64d_pkg::COUNT_WIDTH-1:0]  total_q, total_d, total_add;
	logic                              accept;
	logic [6:0]                        sx;
	logic [23:0]                       word;
	logic [1:0]                        add_n;

	assign accept = push & ~q_full;
	assign sx     = sextet_of(code_char);
	assign word   = {pend_q, sx[5:0]};

	always_comb begin
		ph_d   = ph_q;
		pend_d = pend_q;
		total_d = total_q;
		q_wr   = 1'b0;
		add_n  = NB_NONE;
		q_cmd  = '0;
		if (!sx[6]) begin
			if (ph_q == PH_THREE) begin
				add_n = NB_THREE;
			end
		end else begin
			case (ph_q)
				PH_TWO:   add_n = NB_ONE;
				PH_THREE: add_n = NB_TWO;
				default:  add_n = NB_NONE;
			endcase
		end
		total_add = sat_add(total_q, add_n);
		if (accept) begin
			if (!sx[6]) begin
				if (ph_q == PH_THREE) begin
					// full group: three bytes out
					q_wr         = 1'b1;
					q_cmd.b0     = word[23:16];
					q_cmd.b1     = word[15:8];
					q_cmd.b2     = word[7:0];
					q_cmd.nbytes = NB_THREE;
					total_d      = total_add;
					ph_d         = '0;
					pend_d       = '0;
				end else begin
					pend_d = {pend_q[11:0], sx[5:0]};
					ph_d   = ph_q + PH_ONE;
				end
			end else begin
				// terminator: flush the partial group and report the count
				q_wr      = 1'b1;
				q_cmd.eos = 1'b1;
				q_cmd.count = b64d_pkg::count_to_out(total_add);
				case (ph_q)
					PH_TWO: begin
						q_cmd.b0     = pend_q[11:4];
						q_cmd.nbytes = NB_ONE;
					end
					PH_THREE: begin
						q_cmd.b0     = pend_q[17:10];
						q_cmd.b1     = pend_q[9:2];
						q_cmd.nbytes = NB_TWO;
					end
					default: begin
						q_cmd.nbytes = NB_NONE;
					end
				endcase
				ph_d    = '0;
				pend_d  = '0;
				total_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= '0;
			pend_q  <= '0;
			total_q <= '0;
		end else begin
			ph_q    <= ph_d;
			pend_q  <= pend_d;
			total_q <= total_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/b64d_queue.sv
// Short command queue between the front and back ends.
`default_nettype none
module b64d_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire b64d_pkg::cmd_t  wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output b64d_pkg::cmd_t       rd_data,
	output logic                 empty
);

	localparam int CW = b64d_pkg::QAW + 1;
	localparam logic [b64d_pkg::QAW-1:0] LAST_PTR = b64d_pkg::QAW'(b64d_pkg::QDEPTH - 1);

	b64d_pkg::cmd_t            mem_q [b64d_pkg::QDEPTH];
	logic [b64d_pkg::QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]             cnt_q;
	logic                      do_wr, do_rd;

	assign full    = (cnt_q == CW'(b64d_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/b64d_back.sv
// Back end: split each command into result items and hold them in the output register.
`default_nettype none
module b64d_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire b64d_pkg::cmd_t                  head,
	input  wire logic                            head_empty,
	output logic                                 head_rd,
	input  wire logic                            pop,
	output logic                                 empty,
	output logic [7:0]                           data_byte,
	output logic                                 byte_valid,
	output logic                                 end_of_string,
	output logic [b64d_pkg::OUT_COUNT_W-1:0]     decoded_count
);

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       last;
	logic       advance;
	logic       out_valid_q;
	logic [7:0] sel_byte;

	// a marker command still yields one item
	assign last_idx = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
	assign last     = (idx_q == last_idx);
	assign advance  = ~out_valid_q | pop;
	assign head_rd  = advance & ~head_empty & last;
	assign empty    = ~out_valid_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.b0;
			2'd1:    sel_byte = head.b1;
			default: sel_byte = head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			out_valid_q <= ~head_empty;
			if (!head_empty) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !head_empty) begin
			data_byte     <= sel_byte;
			byte_valid    <= (head.nbytes != 2'd0);
			end_of_string <= last & head.eos;
			decoded_count <= (last && head.eos) ? head.count : '0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/base64_stream_decoder.sv
// Top level of the streaming base64 decoder.
//
// Input channel: drive code_char and raise push; the item is taken at a
// rising edge where full is low. Alphabet characters (A-Z, a-z, 0-9, +, /)
// build groups of four sextets; any other byte ends the string.
// Result channel: while empty is low the oldest result sits on data_byte,
// byte_valid, end_of_string and decoded_count; raise pop to take it.
// A full group gives three byte items. A terminator flushes the partial
// group (zero, one or two bytes); its last item carries end_of_string and
// the saturating byte count of the string, or is a marker with byte_valid
// low when nothing is left to flush.
// Path: a result passes through the queue, written at the edge where the character
// that causes it is taken, and then into the output register once the back end advances.
// Throughput: one character per cycle while full is low, one result per cycle
// while pop keeps up; the back end emits one item of a command each cycle, so
// a full group of three bytes holds the back end while the queue soaks up new commands.
// Stall: when pop stays low the output register holds, the four-entry
// queue fills and full rises; nothing is dropped.
// Reset: arst_n clears phase, pending sextets, byte total, queue pointers and count
// and the output valid flag at once; the block is ready once arst_n is released.
`default_nettype none
`include "base64_stream_decoder_assert.svh"
module base64_stream_decoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [7:0]                   code_char,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [7:0]                        data_byte,
	output logic                              byte_valid,
	output logic                              end_of_string,
	output logic [b64d_pkg::OUT_COUNT_W-1:0]  decoded_count
);

	b64d_pkg::cmd_t wr_cmd, head;
	logic           q_wr, q_rd, q_full, q_empty;

	assign full = q_full;

	// classify and track groups
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.code_char (code_char),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_cmd     (wr_cmd)
	);

	// decouple front and back
	b64d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (wr_cmd),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (head),
		.empty   (q_empty)
	);

	// serialize commands into result items
	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_empty    (q_empty),
		.head_rd       (q_rd),
		.pop           (pop),
		.empty         (empty),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string),
		.decoded_count (decoded_count)
	);

	`B64D_ASSERT_SAME(a_count_only_at_end, clk, arst_n, !empty && !end_of_string, decoded_count == '0, "count shown before end of string")
	`B64D_ASSERT_SAME(a_marker_no_data, clk, arst_n, !empty && !byte_valid, end_of_string && data_byte == 8'd0, "marker item carries data")
	`B64D_ASSERT_SAME(a_wr_needs_accept, clk, arst_n, q_wr, push && !full, "command issued without an accepted item")
	`B64D_ASSERT_SAME(a_rd_needs_room, clk, arst_n, q_rd, empty || pop, "command retired while output stalled")

endmodule
`default_nettype wire
